>>> design/cve_pkg.sv
package cve_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int VALUE_BITS = 48;
    localparam int COUNT_BITS = 32;
    localparam int ALPHA_BITS = 17;
    localparam int OUT_BITS   = VALUE_BITS + 1;
    localparam int SUM_BITS   = VALUE_BITS + 3;
    localparam int MAG_BITS   = VALUE_BITS + 2;
    localparam int PROD_BITS  = MAG_BITS + ALPHA_BITS;
    localparam int STEP_BITS  = $clog2(MAG_BITS);
    localparam int CFG_IDX_BITS  = 2;
    localparam int IN_DATA_BITS  = ((COUNT_BITS + 2 * VALUE_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [ALPHA_BITS-1:0] ALPHA_ONE = ALPHA_BITS'(1) << FRAC_BITS;

    localparam logic [CFG_IDX_BITS-1:0] CFG_USE_COUNT  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_USE_VOLUME = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_USE_PRICE  = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ALPHA      = 2'd3;

    typedef struct packed {
        logic                  use_count;
        logic                  use_volume;
        logic                  use_price;
        logic [ALPHA_BITS-1:0] alpha;
    } cfg_t;

endpackage

>>> design/candle_velocity_ema_top.sv
// A candle that starts a series, or arrives with no input enabled, only updates the history.
// Any other candle gives a result on m_tvalid after the bit-serial divide (50 steps) and,
// with smoothing, the shift-add EMA multiply (17 steps), both on the shared datapath.
// s_tready is low while a candle is in work, so no new candle is taken before the last is
// through, and a held result in the output register that is not yet taken stalls it further.
// Reset loads the enables to one and alpha to zero, and clears history and smoothing state.
module candle_velocity_ema_top (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // trade_count[31:0], volume[79:32], close_px[127:80]
    input  logic [cve_pkg::IN_DATA_BITS-1:0]       s_tdata,
    // series_start[0]
    input  logic                                   s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // velocity[48:0], zero fill above
    output logic [cve_pkg::OUT_DATA_BITS-1:0]      m_tdata,
    input  logic                                   cfg_wr_en,
    input  logic [cve_pkg::CFG_IDX_BITS-1:0]       cfg_wr_index,
    input  logic [cve_pkg::ALPHA_BITS-1:0]         cfg_wr_data
);

    localparam int CNT = cve_pkg::COUNT_BITS;
    localparam int VB  = cve_pkg::VALUE_BITS;

    cve_pkg::cfg_t                       cfg_reg;
    logic                                m_tvalid_reg;
    logic [cve_pkg::OUT_DATA_BITS-1:0]   m_tdata_reg;
    logic                                out_free;
    logic                                res_valid;
    logic signed [cve_pkg::OUT_BITS-1:0] res_velocity;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.use_count  <= 1'b1;
            cfg_reg.use_volume <= 1'b1;
            cfg_reg.use_price  <= 1'b1;
            cfg_reg.alpha      <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                cve_pkg::CFG_USE_COUNT:  cfg_reg.use_count  <= cfg_wr_data[0];
                cve_pkg::CFG_USE_VOLUME: cfg_reg.use_volume <= cfg_wr_data[0];
                cve_pkg::CFG_USE_PRICE:  cfg_reg.use_price  <= cfg_wr_data[0];
                cve_pkg::CFG_ALPHA:      cfg_reg.alpha      <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;

    cve_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .series_start (s_tuser),
        .trade_count  (s_tdata[CNT-1:0]),
        .volume       (s_tdata[CNT+VB-1:CNT]),
        .close_px     (s_tdata[CNT+2*VB-1:CNT+VB]),
        .out_free     (out_free),
        .res_valid    (res_valid),
        .res_velocity (res_velocity)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_valid) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_tdata_reg <= cve_pkg::OUT_DATA_BITS'($unsigned(res_velocity));
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> design/cve_core.sv
module cve_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  cve_pkg::cfg_t                     cfg,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              series_start,
    input  logic [cve_pkg::COUNT_BITS-1:0]    trade_count,
    input  logic [cve_pkg::VALUE_BITS-1:0]    volume,
    input  logic [cve_pkg::VALUE_BITS-1:0]    close_px,
    input  logic                              out_free,
    output logic                              res_valid,
    output logic signed [cve_pkg::OUT_BITS-1:0] res_velocity
);

    localparam int VB = cve_pkg::VALUE_BITS;
    localparam int SB = cve_pkg::SUM_BITS;
    localparam int MB = cve_pkg::MAG_BITS;
    localparam int PB = cve_pkg::PROD_BITS;
    localparam int OB = cve_pkg::OUT_BITS;
    localparam int AB = cve_pkg::ALPHA_BITS;
    localparam int TB = cve_pkg::STEP_BITS;
    localparam int CB = cve_pkg::COUNT_BITS + cve_pkg::FRAC_BITS;

    typedef enum logic [2:0] {
        S_IDLE, S_SUM, S_ABS, S_DIV, S_FORM, S_MUL, S_ADJ, S_EMIT
    } state_t;

    state_t               state_reg;
    logic [VB-1:0]        cur_cnt_reg, cur_vol_reg, cur_prc_reg;
    logic [VB-1:0]        prior_cnt_reg, prior_vol_reg, prior_prc_reg;
    logic                 history_valid_reg;
    logic signed [OB-1:0] smoothed_reg;
    logic                 smoothed_valid_reg;
    logic [2:0]           en_reg;
    logic [1:0]           n_reg;
    logic [TB-1:0]        step_reg;
    logic signed [SB-1:0] acc_reg;
    logic                 neg_reg;
    logic [PB-1:0]        work_reg;
    logic [MB-1:0]        mag_reg;
    logic [1:0]           rem_reg;
    logic [AB-1:0]        alpha_reg;
    logic signed [OB-1:0] res_reg;
    logic                 res_valid_reg;

    logic [CB-1:0]        cnt_wide;
    logic [VB-1:0]        cnt_scaled;
    logic [1:0]           n_enabled;
    logic                 first_candle;
    logic [AB-1:0]        alpha_eff;
    logic [VB-1:0]        sel_cur, sel_prior;
    logic                 sel_en;
    logic signed [SB-1:0] sum_term;
    logic [2:0]           div_trial;
    logic                 div_bit;
    logic [MB-1:0]        quotient;
    logic signed [MB-1:0] avg_ext;
    logic signed [MB-1:0] smooth_ext;
    logic signed [MB-1:0] ema_diff;
    logic [PB-1:0]        prod_rounded;
    logic signed [MB-1:0] ema_step;
    logic signed [MB-1:0] ema_new;

    always_comb begin
        cnt_wide   = {trade_count, {cve_pkg::FRAC_BITS{1'b0}}};
        cnt_scaled = (cnt_wide > CB'({VB{1'b1}})) ? {VB{1'b1}} : cnt_wide[VB-1:0];
        n_enabled  = 2'(cfg.use_count) + 2'(cfg.use_volume) + 2'(cfg.use_price);
        first_candle = series_start || !history_valid_reg;
        alpha_eff  = (cfg.alpha > cve_pkg::ALPHA_ONE) ? cve_pkg::ALPHA_ONE : cfg.alpha;

        case (step_reg[1:0])
            2'd0: begin
                sel_cur = cur_cnt_reg; sel_prior = prior_cnt_reg; sel_en = en_reg[0];
            end
            2'd1: begin
                sel_cur = cur_vol_reg; sel_prior = prior_vol_reg; sel_en = en_reg[1];
            end
            2'd2: begin
                sel_cur = cur_prc_reg; sel_prior = prior_prc_reg; sel_en = en_reg[2];
            end
            default: begin
                sel_cur = '0; sel_prior = '0; sel_en = 1'b0;
            end
        endcase
        sum_term = sel_en ? ($signed({3'b000, sel_cur}) - $signed({3'b000, sel_prior}))
                          : '0;

        div_trial = {rem_reg, work_reg[MB-1]};
        div_bit   = (div_trial >= {1'b0, n_reg});

        quotient   = work_reg[MB-1:0];
        avg_ext    = neg_reg ? -$signed(quotient) : $signed(quotient);
        smooth_ext = MB'(smoothed_reg);
        ema_diff   = avg_ext - smooth_ext;

        prod_rounded = work_reg + (PB'(1) << (cve_pkg::FRAC_BITS - 1));
        ema_step     = $signed(prod_rounded[MB+cve_pkg::FRAC_BITS-1:cve_pkg::FRAC_BITS]);
        ema_new      = neg_reg ? (smooth_ext - ema_step) : (smooth_ext + ema_step);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= S_IDLE;
            history_valid_reg  <= 1'b0;
            smoothed_valid_reg <= 1'b0;
            res_valid_reg      <= 1'b0;
        end else begin
            res_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (in_valid) begin
                        history_valid_reg <= 1'b1;
                        if (first_candle || n_enabled == 2'd0) begin
                            prior_cnt_reg <= cnt_scaled;
                            prior_vol_reg <= volume;
                            prior_prc_reg <= close_px;
                            if (first_candle) begin
                                smoothed_valid_reg <= 1'b0;
                            end
                        end else begin
                            cur_cnt_reg <= cnt_scaled;
                            cur_vol_reg <= volume;
                            cur_prc_reg <= close_px;
                            en_reg      <= {cfg.use_price, cfg.use_volume, cfg.use_count};
                            n_reg       <= n_enabled;
                            alpha_reg   <= alpha_eff;
                            acc_reg     <= '0;
                            step_reg    <= '0;
                            state_reg   <= S_SUM;
                        end
                    end
                end
                S_SUM: begin
                    acc_reg  <= acc_reg + sum_term;
                    step_reg <= step_reg + TB'(1);
                    if (step_reg == TB'(2)) begin
                        prior_cnt_reg <= cur_cnt_reg;
                        prior_vol_reg <= cur_vol_reg;
                        prior_prc_reg <= cur_prc_reg;
                        state_reg     <= S_ABS;
                    end
                end
                S_ABS: begin
                    neg_reg   <= acc_reg[SB-1];
                    work_reg  <= PB'(MB'(acc_reg[SB-1] ? -acc_reg : acc_reg));
                    rem_reg   <= '0;
                    step_reg  <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    rem_reg  <= div_bit ? 2'(div_trial - {1'b0, n_reg}) : div_trial[1:0];
                    work_reg <= PB'({work_reg[MB-2:0], div_bit});
                    step_reg <= step_reg + TB'(1);
                    if (step_reg == TB'(MB - 1)) begin
                        state_reg <= S_FORM;
                    end
                end
                S_FORM: begin
                    res_reg <= avg_ext[OB-1:0];
                    if (alpha_reg == '0 || !smoothed_valid_reg) begin
                        state_reg <= S_EMIT;
                    end else begin
                        neg_reg   <= ema_diff[MB-1];
                        mag_reg   <= ema_diff[MB-1] ? MB'(-ema_diff) : MB'(ema_diff);
                        work_reg  <= '0;
                        step_reg  <= '0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: begin
                    work_reg  <= {work_reg[PB-2:0], 1'b0} +
                                 (alpha_reg[AB-1] ? PB'(mag_reg) : '0);
                    alpha_reg <= {alpha_reg[AB-2:0], 1'b0};
                    step_reg  <= step_reg + TB'(1);
                    if (step_reg == TB'(AB - 1)) begin
                        state_reg <= S_ADJ;
                    end
                end
                S_ADJ: begin
                    res_reg   <= ema_new[OB-1:0];
                    state_reg <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        smoothed_reg       <= res_reg;
                        smoothed_valid_reg <= 1'b1;
                        res_valid_reg      <= 1'b1;
                        state_reg          <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign res_valid    = res_valid_reg;
    assign res_velocity = res_reg;

endmodule

>>> sim/tb_candle_velocity_ema_top.sv
`timescale 1ns / 1ps

module tb_candle_velocity_ema_top;

    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 165;
    localparam int QUIET_ITEMS  = 40;
    localparam int DRAIN_PAUSE  = 100;
    localparam int HOLD_CYCLES  = 500;
    localparam int OB           = cve_pkg::OUT_BITS;
    localparam int ODB          = cve_pkg::OUT_DATA_BITS;
    localparam int IB           = cve_pkg::CFG_IDX_BITS;
    localparam int AB           = cve_pkg::ALPHA_BITS;
    localparam logic [47:0] VALUE_MAX = '1;
    localparam logic [31:0] COUNT_MAX = '1;

    typedef enum logic {ROW_CANDLE, ROW_CONFIG} row_kind_t;

    typedef struct packed {
        row_kind_t               kind;
        logic [IB-1:0]           reg_index;
        logic [AB-1:0]           reg_value;
        logic                    start;
        logic [31:0]             count;
        logic [47:0]             volume;
        logic [47:0]             price;
        logic                    fixed;
        logic                    has_result;
        logic [OB-1:0]           velocity;
    } row_t;

    logic                                aclk = 1'b0;
    logic                                aresetn = 1'b0;
    logic                                s_tvalid = 1'b0;
    logic                                s_tready;
    logic [cve_pkg::IN_DATA_BITS-1:0]    s_tdata = '0;
    logic                                s_tuser = 1'b0;
    logic                                m_tvalid;
    logic                                m_tready = 1'b0;
    logic [ODB-1:0]                      m_tdata;
    logic                                cfg_wr_en = 1'b0;
    logic [IB-1:0]                       cfg_wr_index = '0;
    logic [AB-1:0]                       cfg_wr_data = '0;

    // Predictor copy of the registers and the block state.
    bit                            en_count = 1'b1;
    bit                            en_volume = 1'b1;
    bit                            en_price = 1'b1;
    logic [AB-1:0]                 alpha_reg = '0;
    logic [47:0]                   prev_count;
    logic [47:0]                   prev_volume;
    logic [47:0]                   prev_px;
    bit                            history_ok = 1'b0;
    logic signed [OB-1:0]          smooth_est;
    bit                            ema_ok = 1'b0;

    logic [OB-1:0]                 expected_velocity[$];
    int                            mismatch_count = 0;
    int                            hold_cycles = 0;
    bit                            gaps_on = 1'b1;
    bit                            stalls_on = 1'b1;

    candle_velocity_ema_top dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    always #6 aclk = ~aclk;

    function automatic bit predict_velocity(input bit start, input logic [31:0] count,
                                            input logic [47:0] volume, input logic [47:0] price,
                                            output logic [OB-1:0] velocity);
        logic [63:0]        scaled;
        logic [63:0]        now_sum;
        logic [63:0]        old_sum;
        logic [63:0]        enabled;
        logic [63:0]        mag;
        logic [63:0]        weight;
        logic [63:0]        dmag;
        logic [63:0]        nudge;
        logic signed [63:0] avg;
        logic signed [63:0] ema64;
        logic signed [63:0] diff;
        logic signed [63:0] res;
        bit                 first;
        scaled = {16'b0, count, 16'b0};
        now_sum = '0;
        old_sum = '0;
        enabled = '0;
        velocity = '0;
        first = start || !history_ok;
        if (!first) begin
            if (en_count) begin
                now_sum += scaled;
                old_sum += 64'(prev_count);
                enabled++;
            end
            if (en_volume) begin
                now_sum += 64'(volume);
                old_sum += 64'(prev_volume);
                enabled++;
            end
            if (en_price) begin
                now_sum += 64'(price);
                old_sum += 64'(prev_px);
                enabled++;
            end
        end
        prev_count = scaled[47:0];
        prev_volume = volume;
        prev_px = price;
        history_ok = 1'b1;
        if (first) begin
            ema_ok = 1'b0;
            return 1'b0;
        end
        if (enabled == 0)
            return 1'b0;
        if (now_sum >= old_sum) begin
            mag = (now_sum - old_sum) / enabled;
            avg = $signed(mag);
        end else begin
            mag = (old_sum - now_sum) / enabled;
            avg = -$signed(mag);
        end
        weight = (alpha_reg > cve_pkg::ALPHA_ONE) ? 64'(cve_pkg::ALPHA_ONE) : 64'(alpha_reg);
        if (weight == 0 || !ema_ok) begin
            res = avg;
        end else begin
            ema64 = smooth_est;
            diff = avg - ema64;
            dmag = (diff < 0) ? -diff : diff;
            nudge = weight * (dmag >> 16) + ((weight * (dmag & 64'hFFFF) + 64'd32768) >> 16);
            res = (diff < 0) ? ema64 - $signed(nudge) : ema64 + $signed(nudge);
        end
        smooth_est = res[OB-1:0];
        ema_ok = 1'b1;
        velocity = res[OB-1:0];
        return 1'b1;
    endfunction

    function automatic row_t candle(input bit start, input logic [31:0] count,
                                    input logic [47:0] volume, input logic [47:0] price);
        row_t r;
        r = '0;
        r.kind = ROW_CANDLE;
        r.start = start;
        r.count = count;
        r.volume = volume;
        r.price = price;
        return r;
    endfunction

    function automatic row_t candle_fixed(input bit start, input logic [31:0] count,
                                          input logic [47:0] volume,
                                          input logic [47:0] price,
                                          input bit has_result,
                                          input logic [OB-1:0] velocity);
        row_t r;
        r = candle(start, count, volume, price);
        r.fixed = 1'b1;
        r.has_result = has_result;
        r.velocity = velocity;
        return r;
    endfunction

    function automatic row_t config_row(input logic [IB-1:0] index,
                                        input logic [AB-1:0] value);
        row_t r;
        r = '0;
        r.kind = ROW_CONFIG;
        r.reg_index = index;
        r.reg_value = value;
        return r;
    endfunction

    function automatic logic [47:0] next_value(input logic [47:0] prior, input int width);
        logic [47:0] mask;
        logic [47:0] span;
        mask = (48'd1 << width) - 48'd1;
        span = (48'd1 << $urandom_range(0, 20)) - 48'd1;
        case ($urandom_range(0, 9))
            0: return '0;
            1: return mask;
            2, 3, 4: return 48'({$urandom, $urandom}) & mask;
            default: begin
                if ($urandom_range(0, 1) == 0)
                    return (prior + (48'($urandom) & span)) & mask;
                return (prior - (48'($urandom) & span)) & mask;
            end
        endcase
    endfunction

    task automatic send_candle(input row_t r);
        logic [OB-1:0] velocity;
        bit            produced;
        @(negedge aclk);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            s_tdata <= {$urandom, $urandom, $urandom, $urandom};
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= r.start;
        s_tdata <= {r.price, r.volume, r.count};
        do @(posedge aclk); while (!s_tready);
        produced = predict_velocity(r.start, r.count, r.volume, r.price, velocity);
        if (r.fixed) begin
            if (r.has_result)
                expected_velocity.insert(expected_velocity.size(), r.velocity);
        end else if (produced) begin
            expected_velocity.insert(expected_velocity.size(), velocity);
        end
    endtask

    task automatic drain_block;
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_velocity.size() != 0) @(posedge aclk);
        repeat (DRAIN_PAUSE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [IB-1:0] index,
                             input logic [AB-1:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= index;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (index)
            cve_pkg::CFG_USE_COUNT:  en_count = value[0];
            cve_pkg::CFG_USE_VOLUME: en_volume = value[0];
            cve_pkg::CFG_USE_PRICE:  en_price = value[0];
            cve_pkg::CFG_ALPHA:      alpha_reg = value;
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_velocity.size() == 0) begin
                $display("%0t: velocity %h arrived with none expected", $time, m_tdata[OB-1:0]);
                mismatch_count++;
            end else begin
                if (m_tdata[OB-1:0] != expected_velocity[0]) begin
                    $display("%0t: velocity expected %h, got %h", $time, expected_velocity[0],
                             m_tdata[OB-1:0]);
                    mismatch_count++;
                end
                if (m_tdata[ODB-1:OB] != '0) begin
                    $display("%0t: zero fill expected %h, got %h", $time, 7'h0,
                             m_tdata[ODB-1:OB]);
                    mismatch_count++;
                end
                void'(expected_velocity.pop_front());
            end
        end
    end

    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                hold_cycles--;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (stalls_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(0, 4);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        row_t                  plan[$];
        row_t                  r;
        bit                    pending;
        logic [2:0]            enables;
        logic [AB-1:0]         alpha_pick;
        logic [47:0]           sent_count;
        logic [47:0]           sent_volume;
        logic [47:0]           sent_price;
        int                    items;

        pending = 1'b0;
        sent_count = '0;
        sent_volume = '0;
        sent_price = '0;
        plan = '{
            candle_fixed(1'b0, 32'd5, 48'd7, 48'd9, 1'b0, '0),
            candle_fixed(1'b0, 32'd5, 48'd7, 48'd9, 1'b1, '0),
            candle(1'b0, 32'd0, 48'd0, 48'd0),
            candle(1'b0, COUNT_MAX, VALUE_MAX, VALUE_MAX),
            candle(1'b0, 32'd0, 48'd0, 48'd0),
            candle_fixed(1'b1, COUNT_MAX, VALUE_MAX, VALUE_MAX, 1'b0, '0),
            candle_fixed(1'b0, COUNT_MAX, VALUE_MAX, VALUE_MAX, 1'b1, '0),
            candle_fixed(1'b0, COUNT_MAX, VALUE_MAX, VALUE_MAX - 48'd1, 1'b1, '0),
            candle(1'b0, COUNT_MAX, VALUE_MAX - 48'd1, VALUE_MAX - 48'd3),
            config_row(cve_pkg::CFG_ALPHA, cve_pkg::ALPHA_ONE),
            candle(1'b0, 32'd0, 48'd0, 48'd0),
            config_row(cve_pkg::CFG_ALPHA, 17'd1),
            candle(1'b0, COUNT_MAX, VALUE_MAX, VALUE_MAX),
            candle(1'b0, COUNT_MAX, VALUE_MAX, VALUE_MAX),
            config_row(cve_pkg::CFG_ALPHA, 17'h1FFFF),
            candle(1'b0, 32'd100, 48'd200, 48'd300),
            config_row(cve_pkg::CFG_ALPHA, 17'd32768),
            candle(1'b0, 32'd100, 48'd201, 48'd300),
            candle(1'b0, 32'd100, 48'd204, 48'd301),
            config_row(cve_pkg::CFG_USE_COUNT, 17'd0),
            candle(1'b0, 32'd7, 48'd1000, 48'd2000),
            config_row(cve_pkg::CFG_USE_VOLUME, 17'd0),
            candle(1'b0, 32'd8, 48'd3000, 48'd2500),
            config_row(cve_pkg::CFG_USE_PRICE, 17'd0),
            candle_fixed(1'b0, 32'd9, 48'd5, 48'd5, 1'b0, '0),
            config_row(cve_pkg::CFG_USE_VOLUME, 17'd1),
            config_row(cve_pkg::CFG_ALPHA, 17'd0),
            candle(1'b0, 32'd9, 48'd50, 48'd5),
            config_row(cve_pkg::CFG_ALPHA, 17'd40000),
            candle_fixed(1'b1, 32'd3, 48'd70, 48'd6, 1'b0, '0),
            candle(1'b0, 32'd4, 48'd20, 48'd6),
            candle(1'b0, 32'd4, 48'd90000, 48'd6),
            config_row(cve_pkg::CFG_USE_COUNT, 17'd1),
            config_row(cve_pkg::CFG_USE_PRICE, 17'd1),
            candle(1'b0, 32'd1, 48'd2, 48'd3)
        };

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CONFIG) begin
                if (pending) begin
                    drain_block();
                    pending = 1'b0;
                end
                write_reg(plan[i].reg_index, plan[i].reg_value);
            end else begin
                send_candle(plan[i]);
                pending = 1'b1;
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            drain_block();
            gaps_on = (p < PHASES - 2);
            stalls_on = (p < PHASES - 2);
            if (p == 0)
                enables = 3'b111;
            else if (p == 3)
                enables = 3'b000;
            else
                enables = 3'($urandom_range(1, 7));
            case (p % 6)
                0: alpha_pick = '0;
                1: alpha_pick = cve_pkg::ALPHA_ONE;
                2: alpha_pick = 17'd1;
                3: alpha_pick = 17'h1FFFF;
                4: alpha_pick = 17'($urandom_range(1, 65535));
                default: alpha_pick = 17'($urandom_range(65537, 131071));
            endcase
            write_reg(cve_pkg::CFG_USE_COUNT, 17'(enables[0]));
            write_reg(cve_pkg::CFG_USE_VOLUME, 17'(enables[1]));
            write_reg(cve_pkg::CFG_USE_PRICE, 17'(enables[2]));
            write_reg(cve_pkg::CFG_ALPHA, alpha_pick);
            if (p == 1 || p == 6)
                hold_cycles = HOLD_CYCLES;
            items = (p == 3) ? QUIET_ITEMS : PHASE_ITEMS;
            for (int k = 0; k < items; k++) begin
                sent_count = next_value(sent_count, 32);
                sent_volume = next_value(sent_volume, 48);
                sent_price = next_value(sent_price, 48);
                r = candle($urandom_range(0, 29) == 0, sent_count[31:0], sent_volume, sent_price);
                send_candle(r);
            end
        end

        drain_block();
        if (mismatch_count == 0 && expected_velocity.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
